### design/kca_pkg.sv
// Shared types, constants and the key table of the keypad autorepeat block.
`default_nettype none
package kca_pkg;

	localparam int KEY_COUNT   = 11;
	localparam int TABLE_LEN   = 11;
	localparam int TABLE_LIMIT = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;

	localparam int G0_W    = 12;
	localparam int G1_W    = 8;
	localparam int TIME_W  = 32;
	localparam int DELAY_W = 16;
	localparam int KEY_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DELAY_W;

	localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd500;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd175;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [TIME_W-1:0]     time_t;
	typedef logic [DELAY_W-1:0]    delay_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_DELAY = 1'd0,
		REG_REPEAT_DELAY  = 1'd1
	} cfg_reg_t;

	localparam key_t KEY_NONE = '0;

	// Keys found by one scan.
	typedef struct packed {
		key_t pressed;
		key_t clicked;
	} scan_res_t;

	// True when table entry idx reads as pressed (active low) in the given words.
	function automatic logic entry_pressed(input logic [KEY_W-1:0] idx,
			input logic [G0_W-1:0] g0, input logic [G1_W-1:0] g1);
		logic            grp;
		logic            hit;
		logic [G0_W-1:0] mask;
		logic [G0_W-1:0] word;
		grp  = 1'b0;
		hit  = 1'b1;
		mask = '0;
		case (idx)
			4'd0:  begin grp = 1'b0; mask = 12'h004; end
			4'd1:  begin grp = 1'b0; mask = 12'h001; end
			4'd2:  begin grp = 1'b0; mask = 12'h008; end
			4'd3:  begin grp = 1'b0; mask = 12'h002; end
			4'd4:  begin grp = 1'b1; mask = 12'h040; end
			4'd5:  begin grp = 1'b0; mask = 12'h800; end
			4'd6:  begin grp = 1'b0; mask = 12'h100; end
			4'd7:  begin grp = 1'b1; mask = 12'h010; end
			4'd8:  begin grp = 1'b1; mask = 12'h020; end
			4'd9:  begin grp = 1'b1; mask = 12'h080; end
			4'd10: begin grp = 1'b0; mask = 12'h008; end
			default: begin hit = 1'b0; end
		endcase
		word = grp ? {{(G0_W-G1_W){1'b0}}, g1} : g0;
		return hit && ((word & mask) == '0);
	endfunction

endpackage
`default_nettype wire

### design/kca_if.sv
// Scan request and result channel interfaces.
`default_nettype none
interface kca_scan_if;
	logic                       valid;
	logic                       ready;
	logic [kca_pkg::G0_W-1:0]   keys_group0;
	logic [kca_pkg::G1_W-1:0]   keys_group1;
	logic [kca_pkg::TIME_W-1:0] now_ms;
	logic                       clear_repeat;

	modport source (output valid, keys_group0, keys_group1, now_ms, clear_repeat,
		input ready);
	modport sink (input valid, keys_group0, keys_group1, now_ms, clear_repeat,
		output ready);
endinterface

interface kca_result_if;
	logic                      valid;
	logic                      ready;
	logic [kca_pkg::KEY_W-1:0] pressed_key;
	logic [kca_pkg::KEY_W-1:0] clicked_key;
	logic [kca_pkg::KEY_W-1:0] repeat_key;

	modport source (output valid, pressed_key, clicked_key, repeat_key, input ready);
	modport sink (input valid, pressed_key, clicked_key, repeat_key, output ready);
endinterface
`default_nettype wire

### design/keypad_click_autorepeat.sv
// Top level of the keypad scanner with click detection and autorepeat.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  scan     | in  | valid/ready          | keys_group0, keys_group1, now_ms, clear_repeat
//  result   | out | valid/ready          | pressed_key, clicked_key, repeat_key
//  cfg      | in  | cfg_we, no back-pres | cfg_index, cfg_data
//
// One scan request per cycle unless the result is stalled; a scan passes through the
// input register, then the result register. Table decode and the 32-bit timer compare
// sit between the two registers. Reset clears the valid flags, previous scan and repeat
// state, not the scan data, and loads the delays to 500 and 175 ms. A stalled result
// holds in its register while the input register still accepts one more request.
`default_nettype none
module keypad_click_autorepeat (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	kca_scan_if.sink                            scan,
	kca_result_if.source                        result,
	input  wire logic                           cfg_we,
	input  wire logic [kca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kca_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                       valid_s1;
	logic [kca_pkg::G0_W-1:0]   g0_s1;
	logic [kca_pkg::G1_W-1:0]   g1_s1;
	logic [kca_pkg::TIME_W-1:0] now_s1;
	logic                       clr_s1;

	logic                       valid_s2;
	kca_pkg::scan_res_t         keys_s2;
	kca_pkg::key_t              emit_s2;

	logic                       out_free;
	logic                       step;
	kca_pkg::scan_res_t         scan_res;
	kca_pkg::key_t              emit;

	assign out_free   = !valid_s2 || result.ready;
	assign step       = valid_s1 && out_free;
	assign scan.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (scan.ready)
				valid_s1 <= scan.valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			g0_s1  <= scan.keys_group0;
			g1_s1  <= scan.keys_group1;
			now_s1 <= scan.now_ms;
			clr_s1 <= scan.clear_repeat;
		end
		if (step) begin
			keys_s2 <= scan_res;
			emit_s2 <= emit;
		end
	end

	kca_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.g0     (g0_s1),
		.g1     (g1_s1),
		.res    (scan_res)
	);

	kca_repeat u_repeat (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.g0        (g0_s1),
		.g1        (g1_s1),
		.now       (now_s1),
		.clr       (clr_s1),
		.clicked   (scan_res.clicked),
		.emit      (emit)
	);

	assign result.valid       = valid_s2;
	assign result.pressed_key = keys_s2.pressed;
	assign result.clicked_key = keys_s2.clicked;
	assign result.repeat_key  = emit_s2;

endmodule
`default_nettype wire

### design/kca_scan.sv
// Priority decode of pressed and clicked keys, with the previous scan register.
`default_nettype none
module kca_scan (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic [kca_pkg::G0_W-1:0] g0,
	input  wire logic [kca_pkg::G1_W-1:0] g1,
	output kca_pkg::scan_res_t            res
);

	logic [kca_pkg::G0_W-1:0] prev_g0_q;
	logic [kca_pkg::G1_W-1:0] prev_g1_q;

	always_comb begin
		res.pressed = kca_pkg::KEY_NONE;
		res.clicked = kca_pkg::KEY_NONE;
		for (int i = 0; i < kca_pkg::TABLE_LIMIT; i++) begin
			if (res.pressed == kca_pkg::KEY_NONE &&
					kca_pkg::entry_pressed(kca_pkg::KEY_W'(i), g0, g1))
				res.pressed = kca_pkg::KEY_W'(i + 1);
			if (res.clicked == kca_pkg::KEY_NONE &&
					kca_pkg::entry_pressed(kca_pkg::KEY_W'(i), g0, g1) &&
					!kca_pkg::entry_pressed(kca_pkg::KEY_W'(i), prev_g0_q, prev_g1_q))
				res.clicked = kca_pkg::KEY_W'(i + 1);
		end
	end

	// Reset to all zero so every key reads as already down: no click on the first scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_g0_q <= '0;
			prev_g1_q <= '0;
		end else if (step) begin
			prev_g0_q <= g0;
			prev_g1_q <= g1;
		end
	end

endmodule
`default_nettype wire

### design/kca_repeat.sv
// Autorepeat timer: held key, last emission time and the delay registers.
`default_nettype none
module kca_repeat (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [kca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          step,
	input  wire logic [kca_pkg::G0_W-1:0]      g0,
	input  wire logic [kca_pkg::G1_W-1:0]      g1,
	input  wire logic [kca_pkg::TIME_W-1:0]    now,
	input  wire logic                          clr,
	input  wire kca_pkg::key_t                 clicked,
	output kca_pkg::key_t                      emit
);

	kca_pkg::delay_t initial_delay_q;
	kca_pkg::delay_t repeat_delay_q;
	kca_pkg::key_t   held_q;
	kca_pkg::time_t  last_emit_q;
	logic            repeating_q;

	kca_pkg::key_t   held_eff;
	kca_pkg::key_t   held_nxt;
	kca_pkg::time_t  diff;
	kca_pkg::delay_t delay;
	logic            held_down;
	logic            fire;
	logic            restart;

	always_comb begin
		held_eff  = clr ? kca_pkg::KEY_NONE : held_q;
		diff      = now - last_emit_q;
		delay     = repeating_q ? repeat_delay_q : initial_delay_q;
		held_down = (held_eff != kca_pkg::KEY_NONE) &&
			(held_eff <= kca_pkg::KEY_W'(kca_pkg::TABLE_LIMIT)) &&
			kca_pkg::entry_pressed(held_eff - kca_pkg::KEY_W'(1), g0, g1);
		// Negative wrapped difference never fires.
		fire      = !diff[kca_pkg::TIME_W-1] &&
			(diff > {{(kca_pkg::TIME_W-kca_pkg::DELAY_W){1'b0}}, delay});
		restart   = clicked != kca_pkg::KEY_NONE;
		emit      = kca_pkg::KEY_NONE;
		held_nxt  = kca_pkg::KEY_NONE;
		if (restart) begin
			emit     = clicked;
			held_nxt = clicked;
		end else if (held_down) begin
			held_nxt = held_eff;
			if (fire)
				emit = held_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q <= kca_pkg::INITIAL_DELAY_RST;
			repeat_delay_q  <= kca_pkg::REPEAT_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kca_pkg::REG_INITIAL_DELAY: initial_delay_q <= cfg_data;
				kca_pkg::REG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= kca_pkg::KEY_NONE;
			last_emit_q <= '0;
			repeating_q <= 1'b0;
		end else if (step) begin
			held_q <= held_nxt;
			if (restart) begin
				repeating_q <= 1'b0;
				last_emit_q <= now;
			end else if (held_down && fire) begin
				repeating_q <= 1'b1;
				last_emit_q <= now;
			end
		end
	end

endmodule
`default_nettype wire

### design/kca_checker.sv
// Port-level checks on the keypad autorepeat block, bound to its top level.
`default_nettype none
module kca_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [kca_pkg::KEY_W-1:0] pressed_key,
	input wire logic [kca_pkg::KEY_W-1:0] clicked_key,
	input wire logic [kca_pkg::KEY_W-1:0] repeat_key
);

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(pressed_key) &&
			$stable(clicked_key) && $stable(repeat_key))
		else $error("stalled result changed");

	// A clicked key is down, so the first pressed key is at or before it.
	a_click_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && clicked_key != '0 |->
			pressed_key != '0 && pressed_key <= clicked_key)
		else $error("clicked key not among pressed keys");

	// A click emits its own key at once.
	a_click_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && clicked_key != '0 |-> repeat_key == clicked_key)
		else $error("click not emitted");

	// An emitted key is held down in the same scan.
	a_emit_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && repeat_key != '0 |->
			pressed_key != '0 && pressed_key <= repeat_key &&
			repeat_key <= kca_pkg::KEY_W'(kca_pkg::TABLE_LIMIT))
		else $error("emitted key not pressed");

endmodule

bind keypad_click_autorepeat kca_checker u_kca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.pressed_key (result.pressed_key),
	.clicked_key (result.clicked_key),
	.repeat_key  (result.repeat_key)
);
`default_nettype wire
